[rtl/integer_to_text_formatter_defines.svh]
// assertion helpers used by the checker of this block
`ifndef INTEGER_TO_TEXT_FORMATTER_DEFINES_SVH
`define INTEGER_TO_TEXT_FORMATTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define ITF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ITF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/itf_pkg.sv]
package itf_pkg;

    localparam int VALUE_BITS = 32;
    localparam int MAX_FIELD  = 64;

    // input and output field widths
    localparam int VALUE_W = 32;
    localparam int BASE_W  = 6;
    localparam int WIDTH_W = 7;
    localparam int PREC_W  = 6;
    localparam int FLAGS_W = 7;
    localparam int CHAR_W  = 8;

    // division: restoring steps done per clock (VALUE_BITS is a multiple of it)
    localparam int DIV_STEPS  = 8;
    localparam int DIV_CYCLES = VALUE_BITS / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

    localparam int DIG_IDX_W = $clog2(VALUE_BITS);
    localparam int ND_W      = $clog2(VALUE_BITS + 1);
    localparam int LEN_W     = 8;
    localparam int POS_W     = $clog2(MAX_FIELD);

    localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;
    localparam logic [BASE_W-1:0] BASE_OCT = 6'd8;
    localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;

    // flag bit positions
    localparam int FL_ZEROPAD = 0;
    localparam int FL_SIGNED  = 1;
    localparam int FL_PLUS    = 2;
    localparam int FL_SPACE   = 3;
    localparam int FL_LEFT    = 4;
    localparam int FL_PREFIX  = 5;
    localparam int FL_LOWER   = 6;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_STORE,
        S_PREP,
        S_LAYOUT,
        S_EMIT,
        S_ERR
    } state_t;

    typedef struct packed {
        logic load;
        logic div;
        logic store;
        logic prep;
        logic layout;
        logic emit;
        logic err;
    } dp_cmd_t;

    typedef struct packed {
        logic in_bad;
        logic num_zero;
        logic last;
    } dp_stat_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d,
                                                     input logic lower);
        logic [CHAR_W-1:0] d8;
        d8 = CHAR_W'(d);
        if (d8 < 8'd10)
            return CH_ZERO + d8;
        else
            return (lower ? CH_LA : CH_UA) + d8 - 8'd10;
    endfunction

endpackage

[rtl/itf_ctrl.sv]
module itf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  itf_pkg::dp_stat_t stat,
    output itf_pkg::dp_cmd_t  cmd,
    output logic              busy
);
    import itf_pkg::*;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 div_done;

    assign div_done = (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (start)
                    state_next = stat.in_bad ? S_ERR : S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    cnt_next   = '0;
                    state_next = S_STORE;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_STORE:  state_next = stat.num_zero ? S_PREP : S_DIV;
            S_PREP:   state_next = S_LAYOUT;
            S_LAYOUT: state_next = S_EMIT;
            S_EMIT:
            begin
                if (stat.last)
                    state_next = S_IDLE;
            end
            S_ERR:    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            S_DIV:    cmd.div    = 1'b1;
            S_STORE:  cmd.store  = 1'b1;
            S_PREP:   cmd.prep   = 1'b1;
            S_LAYOUT: cmd.layout = 1'b1;
            S_EMIT:   cmd.emit   = 1'b1;
            S_ERR:    cmd.err    = 1'b1;
            default:  cmd        = '0;
        endcase
    end

endmodule

[rtl/itf_dp.sv]
module itf_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [itf_pkg::VALUE_W-1:0]  value,
    input  logic [itf_pkg::BASE_W-1:0]   base,
    input  logic [itf_pkg::WIDTH_W-1:0]  width,
    input  logic [itf_pkg::PREC_W-1:0]   precision,
    input  logic [itf_pkg::FLAGS_W-1:0] format_flags,
    input  itf_pkg::dp_cmd_t             cmd,
    output itf_pkg::dp_stat_t            stat,
    output logic                         strobe,
    output logic [itf_pkg::CHAR_W-1:0]   out_char,
    output logic                         last_char,
    output logic                         bad_base
);
    import itf_pkg::*;

    // request fields and magnitude
    logic [VALUE_BITS-1:0] num_reg, num_next;
    logic [BASE_W-1:0]     rem_reg, rem_next;
    logic [BASE_W-1:0]     base_reg;
    logic [WIDTH_W-1:0]    width_reg;
    logic [PREC_W-1:0]     prec_reg;
    logic                  zp_reg, left_reg, lower_reg;
    logic [CHAR_W-1:0]     sign_reg;
    logic [1:0]            pfx_reg;
    logic [ND_W-1:0]       nd_reg;
    logic [BASE_W-1:0]     dig_mem [VALUE_BITS];

    // segment lengths and boundaries
    logic [LEN_W-1:0] lead_reg, zeros_reg, trail_reg;
    logic [LEN_W-1:0] b1_reg, b2_reg, b3_reg, b4_reg, b5_reg, total_reg;
    logic [POS_W-1:0] pos_reg;

    logic                strobe_reg;
    logic [CHAR_W-1:0]   char_reg;
    logic                last_reg, bad_reg;

    // load
    logic [VALUE_BITS-1:0] in_val;
    logic                  in_neg;
    logic [CHAR_W-1:0]     in_sign;
    logic [1:0]            in_pfx;

    // prep
    logic [LEN_W-1:0]        nd_ext, prec_eff, sz_pos, zpad;
    logic signed [LEN_W:0]   size_s;
    logic                    sign_on;

    // emit
    logic [LEN_W-1:0]  pos_ext, didx;
    logic [CHAR_W-1:0] ch;
    logic              is_last;

    assign stat.in_bad   = (base < BASE_MIN) || (base > BASE_MAX);
    assign stat.num_zero = (num_reg == '0);
    assign stat.last     = is_last;

    always_comb
    begin
        in_val = VALUE_BITS'(value);
        in_neg = format_flags[FL_SIGNED] && in_val[VALUE_BITS-1];
        if (in_neg)
            in_sign = CH_MINUS;
        else if (format_flags[FL_PLUS])
            in_sign = CH_PLUS;
        else if (format_flags[FL_SPACE])
            in_sign = CH_SPACE;
        else
            in_sign = CH_NUL;
        if (format_flags[FL_PREFIX] && base == BASE_HEX)
            in_pfx = 2'd2;
        else if (format_flags[FL_PREFIX] && base == BASE_OCT)
            in_pfx = 2'd1;
        else
            in_pfx = 2'd0;
    end

    // several restoring division steps, quotient bits shift into the dividend
    always_comb
    begin
        logic [VALUE_BITS-1:0] q;
        logic [BASE_W:0]       r;
        q = num_reg;
        r = {1'b0, rem_reg};
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            r = {r[BASE_W-1:0], q[VALUE_BITS-1]};
            q = {q[VALUE_BITS-2:0], 1'b0};
            if (r >= {1'b0, base_reg})
            begin
                r    = r - {1'b0, base_reg};
                q[0] = 1'b1;
            end
        end
        num_next = q;
        rem_next = r[BASE_W-1:0];
    end

    always_comb
    begin
        nd_ext   = LEN_W'(nd_reg);
        prec_eff = (nd_ext > LEN_W'(prec_reg)) ? nd_ext : LEN_W'(prec_reg);
        sign_on  = (sign_reg != CH_NUL);
        size_s   = $signed((LEN_W+1)'(width_reg)) - $signed((LEN_W+1)'(sign_on))
                 - $signed((LEN_W+1)'(pfx_reg)) - $signed((LEN_W+1)'(prec_eff));
        sz_pos   = size_s[LEN_W] ? '0 : size_s[LEN_W-1:0];
        zpad     = zp_reg ? sz_pos : '0;
    end

    always_comb
    begin
        pos_ext = LEN_W'(pos_reg);
        didx    = b5_reg - pos_ext - 8'd1;
        if (pos_ext < b1_reg)
            ch = CH_SPACE;
        else if (pos_ext < b2_reg)
            ch = sign_reg;
        else if (pos_ext < b3_reg)
            ch = (pos_ext == b2_reg) ? CH_ZERO : (lower_reg ? CH_LX : CH_UX);
        else if (pos_ext < b4_reg)
            ch = CH_ZERO;
        else if (pos_ext < b5_reg)
            ch = digit_char(dig_mem[didx[DIG_IDX_W-1:0]], lower_reg);
        else
            ch = CH_SPACE;
        // text beyond the field limit is cut off
        is_last = (pos_ext + 8'd1 == total_reg) || (pos_reg == POS_W'(MAX_FIELD - 1));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            num_reg   <= in_neg ? (~in_val + 1'b1) : in_val;
            rem_reg   <= '0;
            nd_reg    <= '0;
            base_reg  <= base;
            width_reg <= width;
            prec_reg  <= precision;
            zp_reg    <= format_flags[FL_ZEROPAD] && !format_flags[FL_LEFT];
            left_reg  <= format_flags[FL_LEFT];
            lower_reg <= format_flags[FL_LOWER];
            sign_reg  <= in_sign;
            pfx_reg   <= in_pfx;
        end
        if (cmd.div)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
        if (cmd.store)
        begin
            dig_mem[nd_reg[DIG_IDX_W-1:0]] <= rem_reg;
            nd_reg  <= nd_reg + 1'b1;
            rem_reg <= '0;
        end
        if (cmd.prep)
        begin
            lead_reg  <= (!zp_reg && !left_reg) ? sz_pos : '0;
            zeros_reg <= zpad + prec_eff - nd_ext;
            trail_reg <= left_reg ? sz_pos : '0;
        end
        if (cmd.layout)
        begin
            b1_reg    <= lead_reg;
            b2_reg    <= lead_reg + LEN_W'(sign_on);
            b3_reg    <= lead_reg + LEN_W'(sign_on) + LEN_W'(pfx_reg);
            b4_reg    <= lead_reg + LEN_W'(sign_on) + LEN_W'(pfx_reg) + zeros_reg;
            b5_reg    <= lead_reg + LEN_W'(sign_on) + LEN_W'(pfx_reg) + zeros_reg + nd_ext;
            total_reg <= lead_reg + LEN_W'(sign_on) + LEN_W'(pfx_reg) + zeros_reg + nd_ext
                       + trail_reg;
            pos_reg   <= '0;
        end
        if (cmd.emit)
        begin
            pos_reg  <= pos_reg + 1'b1;
            char_reg <= ch;
            last_reg <= is_last;
            bad_reg  <= 1'b0;
        end
        if (cmd.err)
        begin
            char_reg <= CH_NUL;
            last_reg <= 1'b1;
            bad_reg  <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= cmd.emit || cmd.err;
    end

    assign strobe    = strobe_reg;
    assign out_char  = char_reg;
    assign last_char = last_reg;
    assign bad_base  = bad_reg;

endmodule

[rtl/integer_to_text_formatter.sv]
// bad base: the single error result comes from the S_ERR state via the output registers.
// otherwise busy covers D digits, the prep and layout steps and N characters;
// each digit passes through the shared divider (8 quotient bits per
// cycle) and a store step. characters follow one per cycle, each registered.
// strobe marks each result for one cycle; the receiver cannot stall.
// async active-low reset returns the controller to idle with no result pending.
module integer_to_text_formatter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [itf_pkg::VALUE_W-1:0]  value,
    input  logic [itf_pkg::BASE_W-1:0]   base,
    input  logic [itf_pkg::WIDTH_W-1:0]  width,
    input  logic [itf_pkg::PREC_W-1:0]   precision,
    input  logic [itf_pkg::FLAGS_W-1:0] format_flags,
    output logic                         strobe,
    output logic [itf_pkg::CHAR_W-1:0]   out_char,
    output logic                         last_char,
    output logic                         bad_base
);
    import itf_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    itf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    itf_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (value),
        .base         (base),
        .width        (width),
        .precision    (precision),
        .format_flags (format_flags),
        .cmd          (cmd),
        .stat         (stat),
        .strobe       (strobe),
        .out_char     (out_char),
        .last_char    (last_char),
        .bad_base     (bad_base)
    );

endmodule

[rtl/itf_checker.sv]
`include "integer_to_text_formatter_defines.svh"

module itf_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [itf_pkg::BASE_W-1:0]  base,
    input logic                        strobe,
    input logic [itf_pkg::CHAR_W-1:0]  out_char,
    input logic                        last_char,
    input logic                        bad_base
);
    import itf_pkg::*;

    // a taken request keeps the block busy in the next cycle
    `ITF_ASSERT_NXT(a_busy_after_req, start && !busy, busy, "busy low after request")

    // the error result is a lone nul character
    `ITF_ASSERT_IMP(a_err_shape, strobe && bad_base, last_char && out_char == CH_NUL,
                    "error result malformed")

    // a bad base is answered from the S_ERR state through the output registers
    `ITF_ASSERT_IMP(a_err_timing, start && !busy && (base < BASE_MIN || base > BASE_MAX),
                    ##2 (strobe && bad_base), "missing error result")

    // characters of one field come without gaps
    `ITF_ASSERT_NXT(a_no_gap, strobe && !last_char, strobe, "gap inside a field")

    // formatted text never carries a nul
    `ITF_ASSERT_IMP(a_no_nul, strobe && !bad_base, out_char != CH_NUL, "nul in field text")

endmodule

bind integer_to_text_formatter itf_checker u_itf_checker (.*);
